/* sv/message_slot_pool_timeout_unit_assert.svh */
// ----------------------------------------------------------------------------
// message_slot_pool_timeout_unit_assert
// Assertion macros shared by the slot pool modules. They sample on i_clk and
// are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_SLOT_POOL_TIMEOUT_UNIT_ASSERT_SVH
`define MESSAGE_SLOT_POOL_TIMEOUT_UNIT_ASSERT_SVH

// Same-cycle implication
`define MSPT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MSPT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mspt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_pkg
// Types and fixed widths shared by the message slot pool controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package mspt_pkg;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int EVENT_W   = 16;
    localparam int DEVICE_W  = 8;
    localparam int VALUE_W   = 32;
    localparam int TIMEOUT_W = 16;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 2;

    // Reciprocal used to divide the timeout by the tick period
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Wide slot number, holds pool sizes up to 255
    localparam int SLOT_WIDE_W = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEND    = 2'd0,
        ACT_WAIT    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_NOMATCH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_POSTED = 2'd1,
        PH_TAKEN  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_SEND_PICK = 3'd1,
        ST_SEND_WR   = 3'd2,
        ST_SCAN_RD   = 3'd3,
        ST_WAIT_CMP  = 3'd4,
        ST_TICK_UPD  = 3'd5,
        ST_RESULT    = 3'd6
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic send_pick;
        logic send_write;
        logic wait_check;
        logic tick_upd;
        logic scan_inc;
        logic release_slot;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_action action;
        logic    match;
        logic    last;
        logic    out_busy;
    } t_dp_sts;

endpackage

/* sv/mspt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_ctrl
// Sequencer for the slot pool: takes a transaction, steps the datapath
// through send, scan or release, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mspt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [1:0]                i_action,
    output logic                      o_in_stall,
    input  mspt_pkg::t_dp_sts         i_sts,
    output mspt_pkg::t_dp_cmd         o_cmd
);
    import mspt_pkg::*;

    `include "message_slot_pool_timeout_unit_assert.svh"

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_action'(i_action))
                        ACT_SEND:    n_state = ST_SEND_PICK;
                        ACT_RELEASE: n_state = ST_RESULT;
                        ACT_WAIT:    n_state = ST_SCAN_RD;
                        ACT_TICK:    n_state = ST_SCAN_RD;
                    endcase
                end
            end
            ST_SEND_PICK: n_state = ST_SEND_WR;
            ST_SEND_WR:   n_state = ST_RESULT;
            ST_SCAN_RD: begin
                n_state = (i_sts.action == ACT_WAIT) ? ST_WAIT_CMP : ST_TICK_UPD;
            end
            ST_WAIT_CMP: begin
                n_state = (i_sts.match || i_sts.last) ? ST_RESULT : ST_SCAN_RD;
            end
            ST_TICK_UPD: begin
                n_state = i_sts.last ? ST_RESULT : ST_SCAN_RD;
            end
            ST_RESULT: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE:      o_cmd.load_in    = i_in_valid;
            ST_SEND_PICK: o_cmd.send_pick  = 1'b1;
            ST_SEND_WR:   o_cmd.send_write = 1'b1;
            ST_SCAN_RD:   o_cmd            = '0;
            ST_WAIT_CMP: begin
                o_cmd.wait_check = 1'b1;
                o_cmd.scan_inc   = !i_sts.match && !i_sts.last;
            end
            ST_TICK_UPD: begin
                o_cmd.tick_upd = 1'b1;
                o_cmd.scan_inc = !i_sts.last;
            end
            ST_RESULT: begin
                o_cmd.out_load     = !i_sts.out_busy;
                o_cmd.release_slot = !i_sts.out_busy && (i_sts.action == ACT_RELEASE);
            end
            default: o_cmd = '0;
        endcase
    end

    // Checks
    `MSPT_ASSERT_NXT(a_accept_leaves_idle, o_cmd.load_in, r_state != ST_IDLE,
        "accepted transaction did not start work")
    `MSPT_ASSERT_IMP(a_scan_only_wait_tick, r_state == ST_SCAN_RD,
        i_sts.action == ACT_WAIT || i_sts.action == ACT_TICK,
        "slot scan for an action that needs none")
    `MSPT_ASSERT_NXT(a_tick_ends_at_last, r_state == ST_TICK_UPD && i_sts.last,
        r_state == ST_RESULT, "tick scan ran past the last slot")

endmodule

/* sv/mspt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspt_datapath
// Slot storage, lowest-idle search, per-slot compare and ageing, timeout
// scaling and the output register of the slot pool.
// ----------------------------------------------------------------------------
module mspt_datapath #(
    parameter int SLOTS   = 16,
    parameter int TICK_MS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mspt_pkg::t_dp_cmd                 i_cmd,
    output mspt_pkg::t_dp_sts                 o_sts,
    input  logic [1:0]                        i_action,
    input  logic [mspt_pkg::EVENT_W-1:0]      i_event_code,
    input  logic [mspt_pkg::DEVICE_W-1:0]     i_device_id,
    input  logic [mspt_pkg::VALUE_W-1:0]      i_message_value,
    input  logic [mspt_pkg::TIMEOUT_W-1:0]    i_timeout_ms,
    input  logic [mspt_pkg::INDEX_W-1:0]      i_slot_index,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [mspt_pkg::STATUS_W-1:0]     o_status,
    output logic [mspt_pkg::INDEX_W-1:0]      o_granted_slot,
    output logic [mspt_pkg::VALUE_W-1:0]      o_read_value
);
    import mspt_pkg::*;

    `include "message_slot_pool_timeout_unit_assert.svh"

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PROD_W    = TIMEOUT_W + RECIP_W;
    localparam int RECIP_ONE = 1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((RECIP_ONE + TICK_MS - 1) / TICK_MS);
    localparam logic [SLOT_W-1:0]  LAST_IDX = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_WIDE_W-1:0] SLOTS_WIDE = SLOT_WIDE_W'(SLOTS);

    // Captured transaction
    t_action                r_action;
    logic [EVENT_W-1:0]     r_event;
    logic [DEVICE_W-1:0]    r_device;
    logic [VALUE_W-1:0]     r_value;
    logic [TIMEOUT_W-1:0]   r_timeout;
    logic [INDEX_W-1:0]     r_rel_index;

    // Slot state
    t_phase                 r_phase [SLOTS];
    logic [EVENT_W-1:0]     mem_event  [SLOTS];
    logic [DEVICE_W-1:0]    mem_device [SLOTS];
    logic [TIMEOUT_W-1:0]   mem_ticks  [SLOTS];
    logic [VALUE_W-1:0]     mem_value  [SLOTS];

    logic [EVENT_W-1:0]     r_rd_event;
    logic [DEVICE_W-1:0]    r_rd_device;
    logic [TIMEOUT_W-1:0]   r_rd_ticks;
    logic [VALUE_W-1:0]     r_rd_value;

    // Scan and send working registers
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      n_slot;
    logic                   r_full;
    logic                   n_full;
    logic [PROD_W-1:0]      r_prod;

    // Result and output registers
    t_status                r_res_status;
    logic [SLOT_W-1:0]      r_res_slot;
    logic [VALUE_W-1:0]     r_res_value;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [INDEX_W-1:0]     r_out_slot;
    logic [VALUE_W-1:0]     r_out_value;

    logic                   w_match;
    logic                   w_last;
    logic                   w_tick_live;
    logic                   w_tick_expire;
    logic [TIMEOUT_W-1:0]   w_ticks_dec;
    logic                   w_ticks_we;
    logic [SLOT_W-1:0]      w_ticks_addr;
    logic [TIMEOUT_W-1:0]   w_ticks_data;
    logic [SLOT_WIDE_W-1:0] w_rel_wide;
    logic                   w_rel_ok;
    logic [SLOT_W-1:0]      w_rel_slot;
    logic [SLOT_WIDE_W-1:0] w_res_slot_wide;

    // Find the lowest idle slot
    always_comb begin
        n_slot = '0;
        n_full = 1'b1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_phase[i] == PH_IDLE) begin
                n_slot = SLOT_W'(i);
                n_full = 1'b0;
            end
        end
    end

    // Compare and age the slot under the scan pointer
    always_comb begin
        w_match       = (r_phase[r_idx] == PH_POSTED) && (r_rd_event == r_event) &&
                        (r_rd_device == r_device);
        w_last        = (r_idx == LAST_IDX);
        w_tick_live   = (r_phase[r_idx] == PH_POSTED) && (r_rd_ticks != '0);
        w_ticks_dec   = r_rd_ticks - TIMEOUT_W'(1);
        w_tick_expire = w_tick_live && (w_ticks_dec == '0);
    end

    // Release index, ignored beyond the pool
    always_comb begin
        w_rel_wide = SLOT_WIDE_W'(r_rel_index);
        w_rel_ok   = (w_rel_wide < SLOTS_WIDE);
        w_rel_slot = w_rel_wide[SLOT_W-1:0];
    end

    // Select the ticks write port
    always_comb begin
        w_ticks_we   = 1'b0;
        w_ticks_addr = r_idx;
        w_ticks_data = w_ticks_dec;
        if (i_cmd.send_write && !r_full) begin
            w_ticks_we   = 1'b1;
            w_ticks_addr = r_slot;
            w_ticks_data = r_prod[RECIP_SHIFT +: TIMEOUT_W];
        end else if (i_cmd.tick_upd && w_tick_live) begin
            w_ticks_we = 1'b1;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action    <= t_action'(i_action);
            r_event     <= i_event_code;
            r_device    <= i_device_id;
            r_value     <= i_message_value;
            r_timeout   <= i_timeout_ms;
            r_rel_index <= i_slot_index;
        end
    end

    // Slot memories: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.send_write && !r_full) begin
            mem_event[r_slot]  <= r_event;
            mem_device[r_slot] <= r_device;
            mem_value[r_slot]  <= r_value;
        end
        if (w_ticks_we) begin
            mem_ticks[w_ticks_addr] <= w_ticks_data;
        end
        r_rd_event  <= mem_event[r_idx];
        r_rd_device <= mem_device[r_idx];
        r_rd_ticks  <= mem_ticks[r_idx];
        r_rd_value  <= mem_value[r_idx];
    end

    // Slot phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_phase[i] <= PH_IDLE;
            end
        end else if (i_cmd.send_write && !r_full) begin
            r_phase[r_slot] <= PH_POSTED;
        end else if (i_cmd.wait_check && w_match) begin
            r_phase[r_idx] <= PH_TAKEN;
        end else if (i_cmd.tick_upd && w_tick_expire) begin
            r_phase[r_idx] <= PH_IDLE;
        end else if (i_cmd.release_slot && w_rel_ok) begin
            r_phase[w_rel_slot] <= PH_IDLE;
        end
    end

    // Scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_in) begin
            r_idx <= '0;
        end else if (i_cmd.scan_inc) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
    end

    // Pick the send slot and scale the timeout to ticks
    always_ff @(posedge i_clk) begin
        if (i_cmd.send_pick) begin
            r_slot <= n_slot;
            r_full <= n_full;
            r_prod <= PROD_W'(r_timeout) * PROD_W'(RECIP);
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_res_status <= STS_OK;
            r_res_slot   <= '0;
            r_res_value  <= '0;
        end else if (i_cmd.send_write) begin
            r_res_status <= r_full ? STS_FULL : STS_OK;
            r_res_slot   <= r_full ? '0 : r_slot;
        end else if (i_cmd.wait_check && w_match) begin
            r_res_status <= STS_OK;
            r_res_slot   <= r_idx;
            r_res_value  <= r_rd_value;
        end else if (i_cmd.wait_check && w_last) begin
            r_res_status <= STS_NOMATCH;
        end
    end

    assign w_res_slot_wide = SLOT_WIDE_W'(r_res_slot);

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= w_res_slot_wide[INDEX_W-1:0];
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_slot;
    assign o_read_value   = r_out_value;

    assign o_sts.action   = r_action;
    assign o_sts.match    = w_match;
    assign o_sts.last     = w_last;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    // Checks
    `MSPT_ASSERT_IMP(a_idx_in_pool, 1'b1, r_idx <= LAST_IDX,
        "scan pointer beyond the pool")
    `MSPT_ASSERT_IMP(a_send_slot_idle, i_cmd.send_write && !r_full,
        r_phase[r_slot] == PH_IDLE, "send slot no longer idle at write")
    `MSPT_ASSERT_NXT(a_expire_frees, i_cmd.tick_upd && w_tick_expire,
        r_phase[$past(r_idx)] == PH_IDLE, "expired slot not freed")

endmodule

/* sv/message_slot_pool_timeout_unit.sv */
// Accept to result valid: send runs ST_SEND_PICK, ST_SEND_WR, ST_RESULT;
// release goes to ST_RESULT; wait scans until a slot matches or the last
// slot, tick scans every slot; a result waits in ST_RESULT on a stalled
// output. One transaction at a time; the next can be taken in the cycle after
// the result loads. A scanned slot is read into registers, then compared or
// aged. Reset: synchronous on i_rst_n low; all slots go idle, output empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_slot_pool_timeout_unit
// Message slot pool with per-slot tick timeout: send, wait, release and tick
// over a fixed set of slots, built as a sequencer and a datapath.
// ----------------------------------------------------------------------------
module message_slot_pool_timeout_unit #(
    parameter int SLOTS   = 16,
    parameter int TICK_MS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mspt_pkg::ACTION_W-1:0]     i_action,
    input  logic [mspt_pkg::EVENT_W-1:0]      i_event_code,
    input  logic [mspt_pkg::DEVICE_W-1:0]     i_device_id,
    input  logic [mspt_pkg::VALUE_W-1:0]      i_message_value,
    input  logic [mspt_pkg::TIMEOUT_W-1:0]    i_timeout_ms,
    input  logic [mspt_pkg::INDEX_W-1:0]      i_slot_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mspt_pkg::STATUS_W-1:0]     o_status,
    output logic [mspt_pkg::INDEX_W-1:0]      o_granted_slot,
    output logic [mspt_pkg::VALUE_W-1:0]      o_read_value
);
    import mspt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    mspt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Slot storage and result path
    mspt_datapath #(
        .SLOTS   (SLOTS),
        .TICK_MS (TICK_MS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_action        (i_action),
        .i_event_code    (i_event_code),
        .i_device_id     (i_device_id),
        .i_message_value (i_message_value),
        .i_timeout_ms    (i_timeout_ms),
        .i_slot_index    (i_slot_index),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_granted_slot  (o_granted_slot),
        .o_read_value    (o_read_value)
    );

endmodule

/* sim/message_slot_pool_timeout_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_slot_pool_timeout_unit_tb
// Self-checking bench for the message slot pool. It drives send, wait,
// release and tick transactions with random gaps and output stalls. It keeps
// its own copy of the slot table to work out each reply, and compares every
// reply field by field in arrival order.
// ----------------------------------------------------------------------------
module message_slot_pool_timeout_unit_tb;

    import mspt_pkg::*;

    localparam int          SLOTS        = 16;
    localparam int          TICK_MS      = 10;
    localparam int          CLK_PERIOD   = 20;
    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 2 * SLOTS + 8;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   slot;
        logic [VALUE_W-1:0]   value;
    } t_pool_reply;

    // Clock, reset and block inputs, all known from time zero
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_in_valid      = 1'b0;
    logic [ACTION_W-1:0]    i_action        = '0;
    logic [EVENT_W-1:0]     i_event_code    = '0;
    logic [DEVICE_W-1:0]    i_device_id     = '0;
    logic [VALUE_W-1:0]     i_message_value = '0;
    logic [TIMEOUT_W-1:0]   i_timeout_ms    = '0;
    logic [INDEX_W-1:0]     i_slot_index    = '0;
    logic                   i_out_stall     = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [INDEX_W-1:0]     o_granted_slot;
    logic [VALUE_W-1:0]     o_read_value;

    // Bench copy of the slot table
    t_phase                 pool_phase  [SLOTS] = '{default: PH_IDLE};
    logic [EVENT_W-1:0]     pool_event  [SLOTS] = '{default: '0};
    logic [DEVICE_W-1:0]    pool_device [SLOTS] = '{default: '0};
    logic [TIMEOUT_W-1:0]   pool_ticks  [SLOTS] = '{default: '0};
    logic [VALUE_W-1:0]     pool_value  [SLOTS] = '{default: '0};

    t_pool_reply            expected_replies [$];
    t_pool_reply            oldest_reply;
    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count    = 0;
    int unsigned            stall_left     = 0;
    int unsigned            stall_next;
    bit                     quiet          = 1'b0;

    message_slot_pool_timeout_unit #(
        .SLOTS   (SLOTS),
        .TICK_MS (TICK_MS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_event_code    (i_event_code),
        .i_device_id     (i_device_id),
        .i_message_value (i_message_value),
        .i_timeout_ms    (i_timeout_ms),
        .i_slot_index    (i_slot_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_slot  (o_granted_slot),
        .o_read_value    (o_read_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Return a slot to idle with every field cleared
    function automatic void clear_pool_slot(input int s);
        pool_phase[s]  = PH_IDLE;
        pool_event[s]  = '0;
        pool_device[s] = '0;
        pool_ticks[s]  = '0;
        pool_value[s]  = '0;
    endfunction

    // Apply one transaction to the slot table and return the reply it gives
    function automatic t_pool_reply apply_pool_action(
        input t_action              act,
        input logic [EVENT_W-1:0]   evt,
        input logic [DEVICE_W-1:0]  dev,
        input logic [VALUE_W-1:0]   val,
        input logic [TIMEOUT_W-1:0] tmo,
        input logic [INDEX_W-1:0]   idx
    );
        t_pool_reply reply;
        bit          found;
        int          s;
        reply.status = STS_OK;
        reply.slot   = '0;
        reply.value  = '0;
        found        = 1'b0;
        case (act)
            ACT_SEND: begin
                reply.status = STS_FULL;
                for (s = 0; s < SLOTS; s++) begin
                    if (!found && pool_phase[s] == PH_IDLE) begin
                        pool_phase[s]  = PH_POSTED;
                        pool_event[s]  = evt;
                        pool_device[s] = dev;
                        pool_ticks[s]  = TIMEOUT_W'(tmo / TICK_MS);
                        pool_value[s]  = val;
                        reply.status   = STS_OK;
                        reply.slot     = INDEX_W'(s);
                        found          = 1'b1;
                    end
                end
            end
            ACT_WAIT: begin
                reply.status = STS_NOMATCH;
                for (s = 0; s < SLOTS; s++) begin
                    if (!found && pool_phase[s] == PH_POSTED && pool_event[s] == evt &&
                        pool_device[s] == dev) begin
                        pool_phase[s] = PH_TAKEN;
                        reply.status  = STS_OK;
                        reply.slot    = INDEX_W'(s);
                        reply.value   = pool_value[s];
                        found         = 1'b1;
                    end
                end
            end
            ACT_RELEASE: begin
                if (int'(idx) < SLOTS) clear_pool_slot(int'(idx));
            end
            default: begin
                // Age posted slots only; a zero count never runs out
                for (s = 0; s < SLOTS; s++) begin
                    if (pool_phase[s] == PH_POSTED && pool_ticks[s] != 0) begin
                        pool_ticks[s] = pool_ticks[s] - 1'b1;
                        if (pool_ticks[s] == 0) clear_pool_slot(s);
                    end
                end
            end
        endcase
        return reply;
    endfunction

    // Offer one transaction after a random gap, hold it until taken, then
    // log the reply it should give
    task automatic issue_request(
        input t_action              act,
        input logic [EVENT_W-1:0]   evt,
        input logic [DEVICE_W-1:0]  dev,
        input logic [VALUE_W-1:0]   val,
        input logic [TIMEOUT_W-1:0] tmo,
        input logic [INDEX_W-1:0]   idx
    );
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_event_code    <= evt;
        i_device_id     <= dev;
        i_message_value <= val;
        i_timeout_ms    <= tmo;
        i_slot_index    <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_replies.push_back(apply_pool_action(act, evt, dev, val, tmo, idx));
    endtask

    // Corner cases: field extremes, mismatches on either key, short and zero
    // timeouts, taken slots left alone by tick, release of idle slots
    task automatic check_directed_cases();
        issue_request(ACT_WAIT,    16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_SEND,    16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF,  4'hF);
        issue_request(ACT_SEND,    16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_SEND,    16'h1234, 8'h5A, 32'h13579BDF, 16'd9,     4'd3);
        issue_request(ACT_SEND,    16'h0001, 8'h01, 32'hA5A5A5A5, 16'd10,    4'd7);
        issue_request(ACT_SEND,    16'h0001, 8'h01, 32'h5A5A5A5A, 16'd29,    4'd8);
        issue_request(ACT_WAIT,    16'h0001, 8'h02, 32'hFFFFFFFF, 16'hFFFF,  4'hF);
        issue_request(ACT_WAIT,    16'h0002, 8'h01, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_TICK,    16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF,  4'hF);
        issue_request(ACT_WAIT,    16'h0001, 8'h01, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_TICK,    16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_TICK,    16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_WAIT,    16'hFFFF, 8'hFF, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_WAIT,    16'hFFFF, 8'hFF, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_RELEASE, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 16'hFFFF,  4'd0);
        issue_request(ACT_RELEASE, 16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_RELEASE, 16'h0000, 8'h00, 32'h0,        16'd0,     4'hF);
        issue_request(ACT_SEND,    16'h0001, 8'h01, 32'h0F0F0F0F, 16'd65534, 4'd0);
        issue_request(ACT_WAIT,    16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_WAIT,    16'h1234, 8'h5A, 32'h0,        16'd0,     4'd0);
        issue_request(ACT_RELEASE, 16'h0000, 8'h00, 32'h0,        16'd0,     4'd1);
        issue_request(ACT_RELEASE, 16'h0000, 8'h00, 32'h0,        16'd0,     4'd2);
        issue_request(ACT_RELEASE, 16'h0000, 8'h00, 32'h0,        16'd0,     4'd4);
        issue_request(ACT_RELEASE, 16'h0000, 8'h00, 32'h0,        16'd0,     4'd0);
    endtask

    // Fill every slot, send past full, take each slot back, then clear all
    task automatic check_pool_exhaustion();
        int s;
        for (s = 0; s < SLOTS + 2; s++)
            issue_request(ACT_SEND, 16'($urandom()), 8'($urandom()), $urandom(),
                          16'($urandom_range(0, TICK_MS - 1)), 4'($urandom()));
        for (s = 0; s < SLOTS; s++)
            issue_request(ACT_WAIT, pool_event[s], pool_device[s], $urandom(),
                          16'($urandom()), 4'($urandom()));
        issue_request(ACT_TICK, 16'($urandom()), 8'($urandom()), $urandom(),
                      16'($urandom()), 4'($urandom()));
        for (s = 0; s < SLOTS; s++)
            issue_request(ACT_RELEASE, 16'($urandom()), 8'($urandom()), $urandom(),
                          16'($urandom()), INDEX_W'(s));
    endtask

    // Mixed traffic over a small set of keys so waits find their messages;
    // idling comes and goes in stretches unless switched off
    task automatic check_mixed_traffic(input int unsigned count, input bit allow_idle);
        logic [EVENT_W-1:0]   event_keys  [4];
        logic [DEVICE_W-1:0]  device_keys [4];
        t_action              act;
        logic [EVENT_W-1:0]   evt;
        logic [DEVICE_W-1:0]  dev;
        logic [TIMEOUT_W-1:0] tmo;
        int unsigned          n;
        int unsigned          pick;
        int                   k;
        int                   s;
        for (k = 0; k < 4; k++) begin
            event_keys[k]  = 16'($urandom());
            device_keys[k] = 8'($urandom());
        end
        quiet = !allow_idle;
        for (n = 0; n < count; n++) begin
            if (allow_idle && n % 128 == 0) quiet = ($urandom_range(0, 3) == 0);
            evt = event_keys[$urandom_range(0, 3)];
            dev = device_keys[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) == 0) begin
                evt = 16'($urandom());
                dev = 8'($urandom());
            end
            case ($urandom_range(0, 9))
                0, 1, 2: tmo = 16'($urandom_range(0, TICK_MS - 1));
                9:       tmo = 16'($urandom());
                default: tmo = 16'($urandom_range(TICK_MS, 8 * TICK_MS));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                act = ACT_SEND;
            end else if (pick < 65) begin
                act = ACT_WAIT;
                // Aim most waits at a posted message, found from a random start
                if ($urandom_range(0, 3) != 0) begin
                    k = $urandom_range(0, SLOTS - 1);
                    for (s = 0; s < SLOTS; s++) begin
                        if (pool_phase[(k + s) % SLOTS] == PH_POSTED) begin
                            evt = pool_event[(k + s) % SLOTS];
                            dev = pool_device[(k + s) % SLOTS];
                            break;
                        end
                    end
                end
            end else if (pick < 83) begin
                act = ACT_TICK;
            end else begin
                act = ACT_RELEASE;
            end
            issue_request(act, evt, dev, $urandom(), tmo, 4'($urandom()));
        end
        quiet = 1'b0;
    endtask

    // Compare each reply with the oldest one due and draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    flag_mismatch("reply with no transaction outstanding",
                                  VALUE_W'(o_status), '0);
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (o_status !== oldest_reply.status)
                        flag_mismatch("status", VALUE_W'(o_status),
                                      VALUE_W'(oldest_reply.status));
                    if (o_granted_slot !== oldest_reply.slot)
                        flag_mismatch("granted_slot", VALUE_W'(o_granted_slot),
                                      VALUE_W'(oldest_reply.slot));
                    if (o_read_value !== oldest_reply.value)
                        flag_mismatch("read_value", o_read_value, oldest_reply.value);
                end
                stall_next = quiet ? 0 : $urandom_range(0, 15);
            end else begin
                stall_next = (stall_left != 0) ? stall_left - 1 : 0;
            end
            stall_left  <= stall_next;
            i_out_stall <= (stall_next != 0);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_directed_cases();
        check_pool_exhaustion();
        check_mixed_traffic(1000, 1'b1);
        check_mixed_traffic(120, 1'b0);
        i_in_valid <= 1'b0;
        // Drain outstanding replies, then watch for strays
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_replies.size() != 0)
            flag_mismatch("replies still outstanding",
                          VALUE_W'(expected_replies.size()), '0);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
